[src/fma_pkg.sv]
// ----------------------------------------------------------------------------
// fma_pkg
// Shared sizes, register indexes and types for the frame moving average.
// ----------------------------------------------------------------------------
`default_nettype none

package fma_pkg;

  localparam int unsigned MAX_BINS   = 1024;
  localparam int unsigned MAX_PERIOD = 16;
  localparam int unsigned SAMPLE_W   = 24;
  localparam int unsigned SUM_W      = 28;

  localparam int unsigned BIN_W    = $clog2(MAX_BINS);
  localparam int unsigned SLOT_W   = $clog2(MAX_PERIOD);
  localparam int unsigned PERIOD_W = 5;
  localparam int unsigned NBINS_W  = 11;
  localparam int unsigned CFG_W    = 11;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned RING_AW  = SLOT_W + BIN_W;

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NBINS  = 1'd1;

  typedef struct packed {
    logic [BIN_W-1:0]    bin;
    logic                last;
    logic [PERIOD_W-1:0] frames;
    logic                ring_full;
    logic                sum_valid;
  } ctl_t;

  function automatic logic [SUM_W-1:0] sext_sum(input logic [SAMPLE_W-1:0] x);
    sext_sum = {{(SUM_W - SAMPLE_W){x[SAMPLE_W-1]}}, x};
  endfunction

endpackage

`default_nettype wire

[src/fma_ram.sv]
// ----------------------------------------------------------------------------
// fma_ram
// Simple dual-port synchronous RAM, read-first, with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module fma_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

[src/fma_seq.sv]
// ----------------------------------------------------------------------------
// fma_seq
// Configuration registers and frame counters: bin, ring slot, filled frames.
// ----------------------------------------------------------------------------
`default_nettype none

module fma_seq (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [fma_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [fma_pkg::CFG_W-1:0]       cfg_data_i,
  input  wire logic                            adv_i,
  output fma_pkg::ctl_t                        ctl_o,
  output logic      [fma_pkg::RING_AW-1:0]     ring_addr_o
);

  logic [fma_pkg::PERIOD_W-1:0] period_q, period_d;
  logic [fma_pkg::NBINS_W-1:0]  nbins_q, nbins_d;
  logic [fma_pkg::BIN_W-1:0]    bin_q, bin_d;
  logic [fma_pkg::SLOT_W-1:0]   slot_q, slot_d;
  logic [fma_pkg::PERIOD_W-1:0] filled_q, filled_d;
  logic                         clear;

  logic [fma_pkg::PERIOD_W-1:0] eff_p;
  logic [fma_pkg::NBINS_W-1:0]  eff_nb;
  logic [fma_pkg::NBINS_W-1:0]  bin_inc;
  logic [fma_pkg::PERIOD_W-1:0] slot_inc;
  logic [fma_pkg::PERIOD_W-1:0] filled_inc;
  logic                         last;

  always_comb begin
    if (period_q == '0) begin
      eff_p = fma_pkg::PERIOD_W'(1);
    end else if (period_q > fma_pkg::PERIOD_W'(fma_pkg::MAX_PERIOD)) begin
      eff_p = fma_pkg::PERIOD_W'(fma_pkg::MAX_PERIOD);
    end else begin
      eff_p = period_q;
    end
    if (nbins_q == '0) begin
      eff_nb = fma_pkg::NBINS_W'(1);
    end else if (nbins_q > fma_pkg::NBINS_W'(fma_pkg::MAX_BINS)) begin
      eff_nb = fma_pkg::NBINS_W'(fma_pkg::MAX_BINS);
    end else begin
      eff_nb = nbins_q;
    end
  end

  assign bin_inc    = fma_pkg::NBINS_W'(bin_q) + fma_pkg::NBINS_W'(1);
  assign slot_inc   = fma_pkg::PERIOD_W'(slot_q) + fma_pkg::PERIOD_W'(1);
  assign filled_inc = filled_q + fma_pkg::PERIOD_W'(1);
  assign last       = (bin_inc >= eff_nb);

  always_comb begin
    period_d = period_q;
    nbins_d  = nbins_q;
    clear    = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fma_pkg::REG_PERIOD: begin
          period_d = cfg_data_i[fma_pkg::PERIOD_W-1:0];
          clear    = 1'b1;
        end
        fma_pkg::REG_NBINS: begin
          nbins_d = cfg_data_i[fma_pkg::NBINS_W-1:0];
          clear   = 1'b1;
        end
        default: begin
          clear = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    bin_d    = bin_q;
    slot_d   = slot_q;
    filled_d = filled_q;
    if (clear) begin
      bin_d    = '0;
      slot_d   = '0;
      filled_d = '0;
    end else if (adv_i) begin
      if (last) begin
        bin_d  = '0;
        slot_d = (slot_inc == eff_p) ? '0 : slot_inc[fma_pkg::SLOT_W-1:0];
        if (filled_q < eff_p) begin
          filled_d = filled_inc;
        end
      end else begin
        bin_d = bin_inc[fma_pkg::BIN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= fma_pkg::PERIOD_W'(8);
      nbins_q  <= fma_pkg::NBINS_W'(fma_pkg::MAX_BINS);
      bin_q    <= '0;
      slot_q   <= '0;
      filled_q <= '0;
    end else begin
      period_q <= period_d;
      nbins_q  <= nbins_d;
      bin_q    <= bin_d;
      slot_q   <= slot_d;
      filled_q <= filled_d;
    end
  end

  always_comb begin
    ctl_o.bin       = bin_q;
    ctl_o.last      = last;
    ctl_o.frames    = (filled_inc > eff_p) ? eff_p : filled_inc;
    ctl_o.ring_full = (filled_q == eff_p);
    ctl_o.sum_valid = (filled_q != '0);
  end

  assign ring_addr_o = {slot_q, bin_q};

endmodule

`default_nettype wire

[src/fma_accum.sv]
// ----------------------------------------------------------------------------
// fma_accum
// Read-modify-write of the window sums, sum forwarding and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fma_accum (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_accept_i,
  input  wire fma_pkg::ctl_t                     ctl_i,
  input  wire logic [fma_pkg::SAMPLE_W-1:0]      sample_re_i,
  input  wire logic [fma_pkg::SAMPLE_W-1:0]      sample_im_i,
  input  wire logic [2*fma_pkg::SAMPLE_W-1:0]    ring_rd_i,
  input  wire logic [2*fma_pkg::SUM_W-1:0]       sum_rd_i,
  input  wire logic                              out_ready_i,
  output logic                                   in_ready_o,
  output logic                                   sum_we_o,
  output logic      [fma_pkg::BIN_W-1:0]         sum_waddr_o,
  output logic      [2*fma_pkg::SUM_W-1:0]       sum_wdata_o,
  output logic                                   out_valid_o,
  output logic      [fma_pkg::SUM_W-1:0]         sum_re_o,
  output logic      [fma_pkg::SUM_W-1:0]         sum_im_o,
  output logic      [fma_pkg::PERIOD_W-1:0]      frames_o,
  output logic      [fma_pkg::BIN_W-1:0]         bin_o,
  output logic                                   last_o
);

  logic                            s1_valid_q;
  fma_pkg::ctl_t                   s1_ctl_q;
  logic [fma_pkg::SAMPLE_W-1:0]    s1_re_q, s1_im_q;
  logic                            s1_fwd_q;
  logic [2*fma_pkg::SUM_W-1:0]     s1_fwd_data_q;
  logic                            s1_adv;

  logic [fma_pkg::SUM_W-1:0] old_re, old_im, drop_re, drop_im, new_re, new_im;

  assign s1_adv     = s1_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_comb begin
    if (s1_fwd_q) begin
      old_re = s1_fwd_data_q[fma_pkg::SUM_W-1:0];
      old_im = s1_fwd_data_q[2*fma_pkg::SUM_W-1:fma_pkg::SUM_W];
    end else if (s1_ctl_q.sum_valid) begin
      old_re = sum_rd_i[fma_pkg::SUM_W-1:0];
      old_im = sum_rd_i[2*fma_pkg::SUM_W-1:fma_pkg::SUM_W];
    end else begin
      old_re = '0;
      old_im = '0;
    end
    if (s1_ctl_q.ring_full) begin
      drop_re = fma_pkg::sext_sum(ring_rd_i[fma_pkg::SAMPLE_W-1:0]);
      drop_im = fma_pkg::sext_sum(ring_rd_i[2*fma_pkg::SAMPLE_W-1:fma_pkg::SAMPLE_W]);
    end else begin
      drop_re = '0;
      drop_im = '0;
    end
    new_re = old_re - drop_re + fma_pkg::sext_sum(s1_re_q);
    new_im = old_im - drop_im + fma_pkg::sext_sum(s1_im_q);
  end

  assign sum_we_o    = s1_adv;
  assign sum_waddr_o = s1_ctl_q.bin;
  assign sum_wdata_o = {new_im, new_re};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (in_accept_i) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept_i) begin
      s1_ctl_q      <= ctl_i;
      s1_re_q       <= sample_re_i;
      s1_im_q       <= sample_im_i;
      s1_fwd_q      <= s1_adv && (s1_ctl_q.bin == ctl_i.bin);
      s1_fwd_data_q <= {new_im, new_re};
    end
    if (s1_adv) begin
      sum_re_o <= new_re;
      sum_im_o <= new_im;
      frames_o <= s1_ctl_q.frames;
      bin_o    <= s1_ctl_q.bin;
      last_o   <= s1_ctl_q.last;
    end
  end

endmodule

`default_nettype wire

[src/frame_moving_average.sv]
// ----------------------------------------------------------------------------
// frame_moving_average
// Boxcar moving sum over frames of complex bins, kept in a ring memory.
// ----------------------------------------------------------------------------
// Each input transaction is registered in stage s1, then its sum in the output register.
// Throughput: one transaction per cycle unless the output stalls. Each bin is a
// read-modify-write of ring RAM (16384 x 48) and sum RAM (1024 x 56), with
// sum forwarding. Reset and any register write clear the counters; stale RAM
// contents are masked by the filled-frames count, so there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_moving_average (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_idx_i,
  input  wire logic [10:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // sample_re, sample_im
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,   // sum_re, sum_im, frames_in_sum, bin_index, pad
  output logic             m_axis_tlast    // last_bin
);

  fma_pkg::ctl_t                    ctl;
  logic [fma_pkg::RING_AW-1:0]      ring_addr;
  logic                             accept;
  logic [2*fma_pkg::SAMPLE_W-1:0]   ring_rd;
  logic [2*fma_pkg::SUM_W-1:0]      sum_rd;
  logic                             sum_we;
  logic [fma_pkg::BIN_W-1:0]        sum_waddr;
  logic [2*fma_pkg::SUM_W-1:0]      sum_wdata;
  logic [fma_pkg::SUM_W-1:0]        sum_re, sum_im;
  logic [fma_pkg::PERIOD_W-1:0]     frames;
  logic [fma_pkg::BIN_W-1:0]        bin_idx;

  assign accept = s_axis_tvalid && s_axis_tready;

  fma_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .adv_i       (accept),
    .ctl_o       (ctl),
    .ring_addr_o (ring_addr)
  );

  fma_ram #(
    .DEPTH (fma_pkg::MAX_BINS * fma_pkg::MAX_PERIOD),
    .WIDTH (2 * fma_pkg::SAMPLE_W)
  ) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (ring_addr),
    .wdata_i (s_axis_tdata),
    .re_i    (accept),
    .raddr_i (ring_addr),
    .rdata_o (ring_rd)
  );

  fma_ram #(
    .DEPTH (fma_pkg::MAX_BINS),
    .WIDTH (2 * fma_pkg::SUM_W)
  ) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (sum_waddr),
    .wdata_i (sum_wdata),
    .re_i    (accept),
    .raddr_i (ctl.bin),
    .rdata_o (sum_rd)
  );

  fma_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (accept),
    .ctl_i       (ctl),
    .sample_re_i (s_axis_tdata[23:0]),
    .sample_im_i (s_axis_tdata[47:24]),
    .ring_rd_i   (ring_rd),
    .sum_rd_i    (sum_rd),
    .out_ready_i (m_axis_tready),
    .in_ready_o  (s_axis_tready),
    .sum_we_o    (sum_we),
    .sum_waddr_o (sum_waddr),
    .sum_wdata_o (sum_wdata),
    .out_valid_o (m_axis_tvalid),
    .sum_re_o    (sum_re),
    .sum_im_o    (sum_im),
    .frames_o    (frames),
    .bin_o       (bin_idx),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, bin_idx, frames, sum_im, sum_re};

`ifndef NO_ASSERTIONS
  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (ctl.bin == '0 && ctl.frames == fma_pkg::PERIOD_W'(1)))
    else $error("register write did not restart the frame counters");

  a_last_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && ctl.last && !cfg_we_i) |=> (ctl.bin == '0))
    else $error("bin counter did not wrap after the last bin");

  a_first_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctl.sum_valid |-> (ctl.frames == fma_pkg::PERIOD_W'(1) && !ctl.ring_full
                        || ctl.ring_full && ctl.frames == fma_pkg::PERIOD_W'(1)))
    else $error("first frame flags inconsistent");

  a_frames_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (frames != '0))
    else $error("output frame count is zero");
`endif

endmodule

`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for frame_moving_average. Complex bins stream in frame
// after frame under several window and frame-length settings. A model of the
// ring and the per-bin sums predicts each output that no plan row gives, and all
// are compared field by field. Both stream sides idle and stall in random bursts.
// ----------------------------------------------------------------------------

module tb;
  import fma_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_ITEMS = 1950;
  localparam int unsigned CALM_ITEMS   = 150;
  localparam int unsigned SETTLE       = 4;
  localparam int unsigned IM_LSB       = SUM_W;
  localparam int unsigned FR_LSB       = 2 * SUM_W;
  localparam int unsigned BIN_LSB      = FR_LSB + PERIOD_W;
  localparam int          PLAN_LEN     = 14;

  localparam logic signed [SAMPLE_W-1:0] S_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] S_MIN = 24'sh800000;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_e;
  typedef enum logic [1:0] {MIX_RANDOM, MIX_ALL_MAX, MIX_ALL_MIN, MIX_CORNERS} data_mix_e;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum_re;
    logic signed [SUM_W-1:0] sum_im;
    logic [PERIOD_W-1:0]     frames;
    logic [BIN_W-1:0]        bin;
    logic                    last;
  } bin_sum_t;

  typedef struct packed {
    row_kind_e                  kind;
    logic [CFG_IDX_W-1:0]       idx;
    logic [CFG_W-1:0]           value;
    logic signed [SAMPLE_W-1:0] re;
    logic signed [SAMPLE_W-1:0] im;
    logic [4:0]                 reps;
    logic                       typed;
    bin_sum_t                   want;
  } plan_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [0:0]       cfg_idx_i;
  logic [10:0]      cfg_data_i;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [47:0]      s_axis_tdata;   // sample_re, sample_im
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [71:0]      m_axis_tdata;   // sum_re, sum_im, frames_in_sum, bin_index, pad
  logic             m_axis_tlast;   // last_bin

  frame_moving_average dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  plan_row_t plan [PLAN_LEN] = '{
    '{ROW_ITEM, REG_PERIOD, 11'd0, S_MIN, S_MAX, 5'd1, 1'b1,
      '{-28'sd8388608, 28'sd8388607, 5'd1, 10'd0, 1'b0}},
    '{ROW_ITEM, REG_PERIOD, 11'd0, S_MAX, S_MIN, 5'd1, 1'b1,
      '{28'sd8388607, -28'sd8388608, 5'd1, 10'd1, 1'b0}},
    '{ROW_ITEM, REG_PERIOD, 11'd0, 24'sd0, 24'sd0, 5'd1, 1'b1,
      '{28'sd0, 28'sd0, 5'd1, 10'd2, 1'b0}},
    '{ROW_ITEM, REG_PERIOD, 11'd0, -24'sd1, 24'sd1, 5'd1, 1'b1,
      '{-28'sd1, 28'sd1, 5'd1, 10'd3, 1'b0}},
    '{ROW_CFG, REG_PERIOD, 11'd0, 24'sd0, 24'sd0, 5'd0, 1'b0, '0},
    '{ROW_CFG, REG_NBINS, 11'd0, 24'sd0, 24'sd0, 5'd0, 1'b0, '0},
    '{ROW_ITEM, REG_PERIOD, 11'd0, S_MAX, S_MAX, 5'd1, 1'b1,
      '{28'sd8388607, 28'sd8388607, 5'd1, 10'd0, 1'b1}},
    '{ROW_ITEM, REG_PERIOD, 11'd0, S_MIN, S_MIN, 5'd1, 1'b1,
      '{-28'sd8388608, -28'sd8388608, 5'd1, 10'd0, 1'b1}},
    '{ROW_CFG, REG_PERIOD, 11'd31, 24'sd0, 24'sd0, 5'd0, 1'b0, '0},
    '{ROW_CFG, REG_NBINS, 11'd2047, 24'sd0, 24'sd0, 5'd0, 1'b0, '0},
    '{ROW_ITEM, REG_PERIOD, 11'd0, 24'sd12345, -24'sd54321, 5'd1, 1'b1,
      '{28'sd12345, -28'sd54321, 5'd1, 10'd0, 1'b0}},
    '{ROW_CFG, REG_NBINS, 11'd1, 24'sd0, 24'sd0, 5'd0, 1'b0, '0},
    '{ROW_ITEM, REG_PERIOD, 11'd0, S_MIN, S_MIN, 5'd16, 1'b0, '0},
    '{ROW_ITEM, REG_PERIOD, 11'd0, S_MAX, S_MAX, 5'd1, 1'b0, '0}
  };

  logic signed [SAMPLE_W-1:0] hist_re [MAX_PERIOD*MAX_BINS];
  logic signed [SAMPLE_W-1:0] hist_im [MAX_PERIOD*MAX_BINS];
  logic signed [SUM_W-1:0]    acc_re [MAX_BINS];
  logic signed [SUM_W-1:0]    acc_im [MAX_BINS];
  int unsigned                bin_pos;
  int unsigned                slot_pos;
  int unsigned                frames_done;
  logic [PERIOD_W-1:0]        period_q;
  logic [NBINS_W-1:0]         nbins_q;

  bin_sum_t    pending_sums [$];
  bin_sum_t    head;
  bin_sum_t    seen;
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned cycles;
  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  bit          calm;

  function automatic void clear_history();
    for (int i = 0; i < MAX_PERIOD * MAX_BINS; i++) begin
      hist_re[i] = '0;
      hist_im[i] = '0;
    end
    for (int i = 0; i < MAX_BINS; i++) begin
      acc_re[i] = '0;
      acc_im[i] = '0;
    end
    bin_pos     = 0;
    slot_pos    = 0;
    frames_done = 0;
  endfunction

  function automatic int unsigned window_len();
    if (period_q == 0) return 1;
    if (period_q > MAX_PERIOD) return MAX_PERIOD;
    return period_q;
  endfunction

  function automatic int unsigned frame_len();
    if (nbins_q == 0) return 1;
    if (nbins_q > MAX_BINS) return MAX_BINS;
    return nbins_q;
  endfunction

  function automatic void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    case (idx)
      REG_PERIOD: period_q = value[PERIOD_W-1:0];
      REG_NBINS:  nbins_q  = value[NBINS_W-1:0];
      default:    return;
    endcase
    clear_history();
  endfunction

  function automatic bin_sum_t predict_window_sum(logic signed [SAMPLE_W-1:0] re,
                                                  logic signed [SAMPLE_W-1:0] im);
    int unsigned p;
    int unsigned nb;
    int unsigned addr;
    int unsigned frames;
    int          total_re;
    int          total_im;
    bin_sum_t    r;
    p        = window_len();
    nb       = frame_len();
    addr     = slot_pos * MAX_BINS + bin_pos;
    total_re = int'(acc_re[bin_pos]) - int'(hist_re[addr]) + int'(re);
    total_im = int'(acc_im[bin_pos]) - int'(hist_im[addr]) + int'(im);
    acc_re[bin_pos] = total_re[SUM_W-1:0];
    acc_im[bin_pos] = total_im[SUM_W-1:0];
    hist_re[addr]   = re;
    hist_im[addr]   = im;
    frames = frames_done + 1;
    if (frames > p) frames = p;
    r.sum_re = acc_re[bin_pos];
    r.sum_im = acc_im[bin_pos];
    r.frames = frames[PERIOD_W-1:0];
    r.bin    = bin_pos[BIN_W-1:0];
    r.last   = (bin_pos + 1 >= nb);
    if (r.last) begin
      bin_pos  = 0;
      slot_pos = (slot_pos + 1) % p;
      if (frames_done < p) frames_done++;
    end else begin
      bin_pos++;
    end
    return r;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] draw_sample(data_mix_e mix);
    logic [31:0] rnd;
    rnd = $urandom;
    case (mix)
      MIX_ALL_MAX: return S_MAX;
      MIX_ALL_MIN: return S_MIN;
      MIX_CORNERS: begin
        case (rnd[1:0])
          2'd0:    return S_MAX;
          2'd1:    return S_MIN;
          2'd2:    return '0;
          default: return '1;
        endcase
      end
      default: return rnd[SAMPLE_W-1:0];
    endcase
  endfunction

  function automatic int unsigned pick_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 10;
      2:       return 30;
      default: return 60;
    endcase
  endfunction

  // Call at a falling edge; returns at the falling edge after acceptance.
  task automatic push_sample(input logic signed [SAMPLE_W-1:0] re,
                             input logic signed [SAMPLE_W-1:0] im,
                             input logic typed, input bin_sum_t want);
    bin_sum_t predicted;
    if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {im, re};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = predict_window_sum(re, im);
    pending_sums.push_back(typed ? want : predicted);
    @(negedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    s_axis_tvalid <= 1'b0;
    while (pending_sums.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    apply_config(idx, value);
  endtask

  task automatic check_field(input string what, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in %s of result %0d: expected %0d, got %0d",
                 what, results_seen, want, got);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!calm && sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 7) - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_sums.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output transaction at cycle %0d", cycles);
      end else begin
        head        = pending_sums.pop_front();
        seen.sum_re = m_axis_tdata[SUM_W-1:0];
        seen.sum_im = m_axis_tdata[IM_LSB +: SUM_W];
        seen.frames = m_axis_tdata[FR_LSB +: PERIOD_W];
        seen.bin    = m_axis_tdata[BIN_LSB +: BIN_W];
        seen.last   = m_axis_tlast;
        check_field("sum_re", head.sum_re, seen.sum_re);
        check_field("sum_im", head.sum_im, seen.sum_im);
        check_field("frames_in_sum", {27'd0, head.frames}, {27'd0, seen.frames});
        check_field("bin_index", {22'd0, head.bin}, {22'd0, seen.bin});
        check_field("last_bin", {31'd0, head.last}, {31'd0, seen.last});
      end
      results_seen++;
    end
  end

  initial begin
    int unsigned items_random;
    int unsigned len;
    int unsigned which;
    int unsigned pick;
    data_mix_e   mix;
    bit          first_phase;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    mismatches     = 0;
    results_seen   = 0;
    cycles         = 0;
    calm           = 1'b0;
    src_idle_pct   = 20;
    sink_stall_pct = 20;
    items_random   = 0;
    first_phase    = 1'b1;
    period_q       = 5'd8;
    nbins_q        = 11'd1024;
    clear_history();
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < PLAN_LEN; r++) begin
      if (plan[r].kind == ROW_CFG) begin
        write_register(plan[r].idx, plan[r].value);
      end else begin
        repeat (plan[r].reps) push_sample(plan[r].re, plan[r].im, plan[r].typed, plan[r].want);
      end
    end

    while (items_random < RANDOM_ITEMS) begin
      if (first_phase) begin
        write_register(REG_PERIOD, CFG_W'($urandom_range(1, 3)));
        write_register(REG_NBINS, $urandom_range(0, 1) ? 11'd1024 : 11'd2047);
        len = MAX_BINS + $urandom_range(4, 40);
        first_phase = 1'b0;
      end else begin
        which = (frame_len() > 64) ? 0 : $urandom_range(0, 2);
        if (which != 2) begin
          pick = $urandom_range(0, 5);
          case (pick)
            0:       write_register(REG_PERIOD, 11'd0);
            1:       write_register(REG_PERIOD, 11'd1);
            2:       write_register(REG_PERIOD, 11'd16);
            3:       write_register(REG_PERIOD, 11'd31);
            default: write_register(REG_PERIOD, CFG_W'($urandom_range(0, 31)));
          endcase
        end
        if (which != 1) begin
          pick = $urandom_range(0, 7);
          case (pick)
            0:       write_register(REG_NBINS, 11'd0);
            1:       write_register(REG_NBINS, 11'd1);
            default: write_register(REG_NBINS, CFG_W'($urandom_range(2, 20)));
          endcase
        end
        len = frame_len() * (window_len() + $urandom_range(1, 6));
        if (len > 320) len = 320;
      end
      pick = $urandom_range(0, 9);
      mix  = (pick < 6) ? MIX_RANDOM : (pick == 6) ? MIX_ALL_MAX :
             (pick == 7) ? MIX_ALL_MIN : MIX_CORNERS;
      if (!calm) begin
        src_idle_pct   = pick_pct();
        sink_stall_pct = pick_pct();
      end
      for (int k = 0; k < len && items_random < RANDOM_ITEMS; k++) begin
        if (items_random >= RANDOM_ITEMS - CALM_ITEMS) begin
          calm         = 1'b1;
          src_idle_pct = 0;
        end
        push_sample(draw_sample(mix), draw_sample(mix), 1'b0, '0);
        items_random++;
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_sums.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (mismatches == 0 && pending_sums.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
